// ----- design/bqd_pkg.sv -----
// ----------------------------------------------------------------------------
// Biquad filter package
// Widths, register indexes, payload types and saturation helpers shared by
// the biquad filter channels, multiplier and top level.
// ----------------------------------------------------------------------------
package bqd_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int COEF_WIDTH      = 32;
   localparam int COEF_FRAC_BITS  = 30;
   localparam int STATE_WIDTH     = 48;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam int MUL_B_WIDTH = STATE_WIDTH / 2;
   localparam int MUL_P_WIDTH = COEF_WIDTH + MUL_B_WIDTH;
   localparam int FULL_WIDTH  = COEF_WIDTH + STATE_WIDTH;
   localparam int FB_WIDTH    = FULL_WIDTH - COEF_FRAC_BITS;
   localparam int WIDE_WIDTH  = STATE_WIDTH + 6;
   localparam int RND_WIDTH   = STATE_WIDTH + 1 - COEF_FRAC_BITS;

   typedef logic signed [SAMPLE_WIDTH-1:0]    sample_type;
   typedef logic signed [COEF_WIDTH-1:0]      coef_type;
   typedef logic signed [STATE_WIDTH-1:0]     state_type;
   typedef logic signed [WIDE_WIDTH-1:0]      wide_type;
   typedef logic [CSR_INDEX_WIDTH-1:0]        csr_index_type;
   typedef logic [COEF_WIDTH-1:0]             mul_a_type;
   typedef logic [MUL_B_WIDTH-1:0]            mul_b_type;
   typedef logic [MUL_P_WIDTH-1:0]            mul_p_type;

   localparam csr_index_type REG_B0 = CSR_INDEX_WIDTH'(0);
   localparam csr_index_type REG_B1 = CSR_INDEX_WIDTH'(1);
   localparam csr_index_type REG_B2 = CSR_INDEX_WIDTH'(2);
   localparam csr_index_type REG_A1 = CSR_INDEX_WIDTH'(3);
   localparam csr_index_type REG_A2 = CSR_INDEX_WIDTH'(4);

   localparam coef_type COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC_BITS;

   typedef struct packed {
      logic      clip;
      state_type value;
   } sat_state_type;

   typedef struct packed {
      logic       clip;
      sample_type value;
   } sat_sample_type;

   function automatic sat_state_type sat_state(input wide_type v);
      logic [WIDE_WIDTH-STATE_WIDTH:0] upper;
      sat_state_type r;
      upper = v[WIDE_WIDTH-1:STATE_WIDTH-1];
      r.clip = !((&upper) || (~|upper));
      if (r.clip) begin
         r.value = v[WIDE_WIDTH-1] ? {1'b1, {(STATE_WIDTH-1){1'b0}}}
                                   : {1'b0, {(STATE_WIDTH-1){1'b1}}};
      end else begin
         r.value = v[STATE_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic sat_sample_type sat_sample(input logic signed [RND_WIDTH-1:0] v);
      logic [RND_WIDTH-SAMPLE_WIDTH:0] upper;
      sat_sample_type r;
      upper = v[RND_WIDTH-1:SAMPLE_WIDTH-1];
      r.clip = !((&upper) || (~|upper));
      if (r.clip) begin
         r.value = v[RND_WIDTH-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end else begin
         r.value = v[SAMPLE_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

// ----- design/bqd_if.sv -----
// ----------------------------------------------------------------------------
// Biquad filter channels
// Valid/ready channels for input samples, filtered results and coefficient
// register writes.
// ----------------------------------------------------------------------------
interface bqd_req_if;
   import bqd_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface bqd_rsp_if;
   import bqd_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_out;
   logic       clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

interface bqd_csr_if;
   import bqd_pkg::*;

   logic          valid;
   logic          ready;
   csr_index_type index;
   coef_type      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/biquad_df2t_filter.sv -----
// ----------------------------------------------------------------------------
// Biquad filter, transposed direct form II
// One second-order IIR section with Q2.30 coefficients and 48-bit states.
// ----------------------------------------------------------------------------
// A sample is taken only while the sequencer is idle, and its result is
// registered in the output register in the last step; the block cannot
// take a new sample until the sequencer is back in idle. The single 32x24
// multiplier forms b0*x, b1*x, b2*x and the low and high halves of a1*y and
// a2*y one after another. A
// result that is not taken holds the output register; the sequencer then
// waits in its last step, and the sample after it is delayed by the stall.
// Coefficient writes are taken in any cycle; make them only while no sample
// is in flight.
module biquad_df2t_filter (
   input  logic   clock,
   input  logic   reset,
   bqd_req_if.sink   req_bus,
   bqd_rsp_if.source rsp_bus,
   bqd_csr_if.sink   csr_bus
);
   import bqd_pkg::*;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_MUL_B0  = 4'd1;
   localparam logic [3:0] ST_MUL_B1  = 4'd2;
   localparam logic [3:0] ST_MUL_B2  = 4'd3;
   localparam logic [3:0] ST_MUL_A1L = 4'd4;
   localparam logic [3:0] ST_MUL_A1H = 4'd5;
   localparam logic [3:0] ST_MUL_A2L = 4'd6;
   localparam logic [3:0] ST_MUL_A2H = 4'd7;
   localparam logic [3:0] ST_ACC_A2  = 4'd8;
   localparam logic [3:0] ST_DONE    = 4'd9;

   localparam logic [FULL_WIDTH-1:0] FB_ROUND  = FULL_WIDTH'(1) << (COEF_FRAC_BITS - 1);
   localparam logic [STATE_WIDTH:0]  OUT_ROUND = (STATE_WIDTH + 1)'(1) << (COEF_FRAC_BITS - 1);

   logic [3:0]                state_ff, state_in;
   coef_type                  coef_ff [5];
   state_type                 delay_one_ff, delay_two_ff;
   logic [MUL_B_WIDTH-1:0]    xmag_ff;
   logic                      xneg_ff;
   state_type                 y_ff;
   logic [STATE_WIDTH-1:0]    ymag_ff;
   logic                      yneg_ff;
   state_type                 bx1_ff, bx2_ff;
   logic [FULL_WIDTH-1:0]     acc_ff;
   logic [FB_WIDTH-1:0]       fbm_ff;
   logic                      fneg_ff;
   logic                      pneg_ff;
   logic                      clip_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   sample_type                rsp_sample_ff;
   logic                      rsp_clip_ff;

   coef_type                  coef_sel;
   mul_a_type                 mul_a;
   mul_b_type                 mul_b;
   logic                      mul_en;
   logic                      op_neg;
   mul_p_type                 prod;
   logic [WIDE_WIDTH-1:0]     bx_mag;
   wide_type                  bx_val;
   logic [FULL_WIDTH-1:0]     full_sum;
   wide_type                  fb_val;
   sat_state_type             y_sat, d1_sat, d2_sat;
   logic [STATE_WIDTH:0]      y_rnd;
   sat_sample_type            out_sat;
   logic                      req_take, out_free;

   assign req_bus.ready   = (state_ff == ST_IDLE);
   assign req_take        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready   = 1'b1;
   assign out_free        = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_valid_in    = ((state_ff == ST_DONE) && out_free)
                            || (rsp_valid_ff && !rsp_bus.ready);

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample_out = rsp_sample_ff;
   assign rsp_bus.clipped    = rsp_clip_ff;

   always_comb begin
      unique case (state_ff)
         ST_MUL_B1:              coef_sel = coef_ff[1];
         ST_MUL_B2:              coef_sel = coef_ff[2];
         ST_MUL_A1L, ST_MUL_A1H: coef_sel = coef_ff[3];
         ST_MUL_A2L, ST_MUL_A2H: coef_sel = coef_ff[4];
         default:                coef_sel = coef_ff[0];
      endcase
   end

   always_comb begin
      mul_en = 1'b0;
      mul_b  = MUL_B_WIDTH'(xmag_ff);
      op_neg = coef_sel[COEF_WIDTH-1] ^ xneg_ff;
      unique case (state_ff)
         ST_MUL_B0, ST_MUL_B1, ST_MUL_B2: begin
            mul_en = 1'b1;
         end
         ST_MUL_A1L, ST_MUL_A2L: begin
            mul_en = 1'b1;
            mul_b  = ymag_ff[MUL_B_WIDTH-1:0];
            op_neg = coef_sel[COEF_WIDTH-1] ^ yneg_ff;
         end
         ST_MUL_A1H, ST_MUL_A2H: begin
            mul_en = 1'b1;
            mul_b  = ymag_ff[STATE_WIDTH-1:MUL_B_WIDTH];
            op_neg = coef_sel[COEF_WIDTH-1] ^ yneg_ff;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   assign mul_a = coef_sel[COEF_WIDTH-1] ? mul_a_type'(-coef_sel) : mul_a_type'(coef_sel);

   bqd_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   assign bx_mag   = {{(WIDE_WIDTH-STATE_WIDTH){1'b0}}, prod[STATE_WIDTH-1:0]};
   assign bx_val   = pneg_ff ? -$signed(bx_mag) : $signed(bx_mag);
   assign full_sum = acc_ff + {prod, {MUL_B_WIDTH{1'b0}}};
   assign fb_val   = fneg_ff ? -$signed({{(WIDE_WIDTH-FB_WIDTH){1'b0}}, fbm_ff})
                             : $signed({{(WIDE_WIDTH-FB_WIDTH){1'b0}}, fbm_ff});

   assign y_sat  = sat_state(bx_val + WIDE_WIDTH'(delay_one_ff));
   assign d1_sat = sat_state(WIDE_WIDTH'(bx1_ff) - fb_val + WIDE_WIDTH'(delay_two_ff));
   assign d2_sat = sat_state(WIDE_WIDTH'(bx2_ff) - fb_val);

   assign y_rnd   = {y_ff[STATE_WIDTH-1], y_ff} + OUT_ROUND;
   assign out_sat = sat_sample(y_rnd[STATE_WIDTH:COEF_FRAC_BITS]);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_take) begin
            state_in = ST_MUL_B0;
         end
         ST_MUL_B0:  state_in = ST_MUL_B1;
         ST_MUL_B1:  state_in = ST_MUL_B2;
         ST_MUL_B2:  state_in = ST_MUL_A1L;
         ST_MUL_A1L: state_in = ST_MUL_A1H;
         ST_MUL_A1H: state_in = ST_MUL_A2L;
         ST_MUL_A2L: state_in = ST_MUL_A2H;
         ST_MUL_A2H: state_in = ST_ACC_A2;
         ST_ACC_A2:  state_in = ST_DONE;
         ST_DONE:    if (out_free) begin
            state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         delay_one_ff <= '0;
         delay_two_ff <= '0;
         coef_ff[0]   <= COEF_ONE;
         coef_ff[1]   <= '0;
         coef_ff[2]   <= '0;
         coef_ff[3]   <= '0;
         coef_ff[4]   <= '0;
         clip_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;

         if (csr_bus.valid && csr_bus.ready) begin
            unique case (csr_bus.index)
               REG_B0:  coef_ff[0] <= csr_bus.data;
               REG_B1:  coef_ff[1] <= csr_bus.data;
               REG_B2:  coef_ff[2] <= csr_bus.data;
               REG_A1:  coef_ff[3] <= csr_bus.data;
               REG_A2:  coef_ff[4] <= csr_bus.data;
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: if (req_take) begin
               clip_ff <= 1'b0;
            end
            ST_MUL_B1: begin
               clip_ff <= clip_ff | y_sat.clip;
            end
            ST_MUL_A2H: begin
               delay_one_ff <= d1_sat.value;
               clip_ff      <= clip_ff | d1_sat.clip;
            end
            ST_DONE: if (out_free) begin
               delay_two_ff <= d2_sat.value;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         pneg_ff <= op_neg;
      end
      unique case (state_ff)
         ST_IDLE: if (req_take) begin
            xneg_ff <= req_bus.sample_in[SAMPLE_WIDTH-1];
            xmag_ff <= req_bus.sample_in[SAMPLE_WIDTH-1]
                       ? MUL_B_WIDTH'(-$signed({req_bus.sample_in[SAMPLE_WIDTH-1],
                                                req_bus.sample_in}))
                       : MUL_B_WIDTH'({1'b0, req_bus.sample_in});
         end
         ST_MUL_B1: begin
            y_ff <= y_sat.value;
         end
         ST_MUL_B2: begin
            bx1_ff  <= bx_val[STATE_WIDTH-1:0];
            yneg_ff <= y_ff[STATE_WIDTH-1];
            ymag_ff <= y_ff[STATE_WIDTH-1] ? STATE_WIDTH'(-y_ff) : STATE_WIDTH'(y_ff);
         end
         ST_MUL_A1L: begin
            bx2_ff <= bx_val[STATE_WIDTH-1:0];
         end
         ST_MUL_A1H, ST_MUL_A2H: begin
            acc_ff <= FULL_WIDTH'(prod) + FB_ROUND;
         end
         ST_MUL_A2L, ST_ACC_A2: begin
            fbm_ff  <= full_sum[FULL_WIDTH-1:COEF_FRAC_BITS];
            fneg_ff <= pneg_ff;
         end
         ST_DONE: if (out_free) begin
            rsp_sample_ff <= out_sat.value;
            rsp_clip_ff   <= clip_ff | d2_sat.clip | out_sat.clip;
         end
         default: ;
      endcase
   end

`ifndef ASSERT_OFF
   property p_take_starts_sequence;
      @(posedge clock) disable iff (reset)
         (req_bus.valid && req_bus.ready) |=> (state_ff == ST_MUL_B0);
   endproperty
   a_take_starts_sequence: assert property (p_take_starts_sequence)
      else $error("accepted beat did not start the multiply sequence");

   property p_result_from_done;
      @(posedge clock) disable iff (reset)
         $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE);
   endproperty
   a_result_from_done: assert property (p_result_from_done)
      else $error("result beat raised outside the final step");

   property p_hold_on_stall;
      @(posedge clock) disable iff (reset)
         (state_ff == ST_DONE && rsp_valid_ff && !rsp_bus.ready)
            |=> (state_ff == ST_DONE) && $stable(delay_two_ff) && $stable(rsp_sample_ff);
   endproperty
   a_hold_on_stall: assert property (p_hold_on_stall)
      else $error("sequencer advanced while result beat was stalled");
`endif

endmodule

// ----- design/bqd_mul.sv -----
// ----------------------------------------------------------------------------
// Biquad shared multiplier
// Unsigned coefficient-magnitude by operand-slice multiplier with a
// registered product, issued in each multiply step of the sequencer.
// ----------------------------------------------------------------------------
module bqd_mul (
   input  logic               clock,
   input  logic               en,
   input  bqd_pkg::mul_a_type a,
   input  bqd_pkg::mul_b_type b,
   output bqd_pkg::mul_p_type prod
);
   import bqd_pkg::*;

   mul_p_type prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= MUL_P_WIDTH'(a) * MUL_P_WIDTH'(b);
      end
   end

   assign prod = prod_ff;

endmodule
